@@ rtl/zsig_pkg.sv @@
package zsig_pkg;

    // Defaults and fixed field widths
    localparam int MAX_SIDE_DEF = 64;
    localparam int CFG_W        = 7;
    localparam int IDX_W        = 6;
    localparam int DIAG_W       = 7;
    localparam int SIDE_RESET   = 8;

    // Register indexes on the configuration port
    localparam int          REG_IDX_W     = 1;
    localparam logic [0:0]  REG_ROW_COUNT = 1'b0;
    localparam logic [0:0]  REG_COL_COUNT = 1'b1;

    // Per-element flags from the step logic
    typedef struct packed {
        logic diag_first;
        logic scan_last;
    } step_flags_t;

endpackage

@@ rtl/zigzag_scan_index_generator.sv @@
// Zigzag scan index generator. Each accepted item (restart = 1 to go back to
// the origin, restart = 0 to advance) yields one result item: the (row, col)
// of the next element in zigzag order over a row_count x col_count matrix,
// its anti-diagonal number, a first-of-diagonal flag and a last-of-scan flag.
// After the last element, or on the first advance after reset, the scan
// starts over at (0,0). Throughput is one item per clock unless out_stall
// holds a result; out_valid rises in the clock after acceptance, set by the
// single result register that follows the next-position logic. in_stall is
// high only while that register holds a result that the sink is stalling.
// Register writes of 0 act as 1 and values above MAX_SIDE act as MAX_SIDE;
// write registers only while idle. A write is stored at the edge sampling it.
module zigzag_scan_index_generator #(
    parameter int MAX_SIDE = zsig_pkg::MAX_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [zsig_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [zsig_pkg::CFG_W-1:0]      cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [zsig_pkg::IDX_W-1:0]      row_index,
    output logic [zsig_pkg::IDX_W-1:0]      col_index,
    output logic [zsig_pkg::DIAG_W-1:0]     diag_number,
    output logic                            diag_first,
    output logic                            scan_last
);

    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = zsig_pkg::IDX_W;
    localparam int DIAG_W = zsig_pkg::DIAG_W;

    logic [SIDE_W-1:0] row_side;
    logic [SIDE_W-1:0] col_side;

    // walk position of the last element handed out
    logic              active_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;

    logic [POS_W-1:0]  row_next;
    logic [POS_W-1:0]  col_next;
    logic [POS_W:0]    diag_next;
    zsig_pkg::step_flags_t flags_next;

    // result register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DIAG_W-1:0] out_diag_reg;
    zsig_pkg::step_flags_t out_flags_reg;

    logic              in_take;

    zsig_cfg #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_side  (row_side),
        .col_side  (col_side)
    );

    zsig_step #(
        .MAX_SIDE (MAX_SIDE),
        .POS_W    (POS_W),
        .SIDE_W   (SIDE_W)
    ) u_step (
        .restart   (restart),
        .active    (active_reg),
        .cur_row   (row_reg),
        .cur_col   (col_reg),
        .row_side  (row_side),
        .col_side  (col_side),
        .next_row  (row_next),
        .next_col  (col_next),
        .next_diag (diag_next),
        .flags     (flags_next)
    );

    // Result register empties or drains this cycle -> room for a new item
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                active_reg <= 1'b1;
                row_reg    <= row_next;
                col_reg    <= col_next;
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_row_reg   <= IDX_W'(row_next);
            out_col_reg   <= IDX_W'(col_next);
            out_diag_reg  <= DIAG_W'(diag_next);
            out_flags_reg <= flags_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = out_row_reg;
    assign col_index   = out_col_reg;
    assign diag_number = out_diag_reg;
    assign diag_first  = out_flags_reg.diag_first;
    assign scan_last   = out_flags_reg.scan_last;

endmodule

@@ rtl/zsig_cfg.sv @@
module zsig_cfg #(
    parameter int MAX_SIDE = zsig_pkg::MAX_SIDE_DEF,
    parameter int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [zsig_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [zsig_pkg::CFG_W-1:0]      cfg_data,
    output logic [SIDE_W-1:0]               row_side,
    output logic [SIDE_W-1:0]               col_side
);

    localparam int SIDE_RST = (zsig_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                                : zsig_pkg::SIDE_RESET;

    logic [SIDE_W-1:0] row_side_reg;
    logic [SIDE_W-1:0] col_side_reg;
    logic [SIDE_W-1:0] clamped;

    // Zero reads as one, anything above the maximum as the maximum
    always_comb
    begin
        if (cfg_data == '0)
        begin
            clamped = SIDE_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_SIDE))
        begin
            clamped = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            clamped = SIDE_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_side_reg <= SIDE_W'(SIDE_RST);
            col_side_reg <= SIDE_W'(SIDE_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                zsig_pkg::REG_ROW_COUNT: row_side_reg <= clamped;
                zsig_pkg::REG_COL_COUNT: col_side_reg <= clamped;
                default:                 row_side_reg <= row_side_reg;
            endcase
        end
    end

    assign row_side = row_side_reg;
    assign col_side = col_side_reg;

endmodule

@@ rtl/zsig_step.sv @@
module zsig_step #(
    parameter int MAX_SIDE = zsig_pkg::MAX_SIDE_DEF,
    parameter int POS_W    = $clog2(MAX_SIDE),
    parameter int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic                  restart,
    input  logic                  active,
    input  logic [POS_W-1:0]      cur_row,
    input  logic [POS_W-1:0]      cur_col,
    input  logic [SIDE_W-1:0]     row_side,
    input  logic [SIDE_W-1:0]     col_side,
    output logic [POS_W-1:0]      next_row,
    output logic [POS_W-1:0]      next_col,
    output logic [POS_W:0]        next_diag,
    output zsig_pkg::step_flags_t flags
);

    localparam int D_W = POS_W + 1;

    logic [SIDE_W-1:0] row_ext;
    logic [SIDE_W-1:0] col_ext;
    logic [SIDE_W-1:0] row_max;
    logic [SIDE_W-1:0] col_max;
    logic [D_W-1:0]    diag;
    logic [D_W-1:0]    diag_nx;
    logic              at_end;
    logic              to_origin;
    logic              up_right;
    logic              down_left;

    assign row_ext = SIDE_W'(cur_row);
    assign col_ext = SIDE_W'(cur_col);
    assign row_max = row_side - SIDE_W'(1);
    assign col_max = col_side - SIDE_W'(1);
    assign diag    = D_W'(cur_row) + D_W'(cur_col);
    assign diag_nx = diag + D_W'(1);

    assign at_end    = (row_ext == row_max) && (col_ext == col_max);
    assign to_origin = restart || !active || (row_ext >= row_side) ||
                       (col_ext >= col_side) || at_end;

    // Move along the diagonal while the neighbor stays inside
    assign up_right  = !diag[0] && (cur_row != '0) && ((col_ext + SIDE_W'(1)) < col_side);
    assign down_left = diag[0] && ((row_ext + SIDE_W'(1)) < row_side) && (cur_col != '0);

    always_comb
    begin
        next_row = '0;
        next_col = '0;
        if (to_origin)
        begin
            next_row = '0;
            next_col = '0;
        end
        else if (up_right)
        begin
            next_row = cur_row - POS_W'(1);
            next_col = cur_col + POS_W'(1);
        end
        else if (down_left)
        begin
            next_row = cur_row + POS_W'(1);
            next_col = cur_col - POS_W'(1);
        end
        else if (!diag_nx[0])
        begin
            // even diagonal starts on the left edge, else on the bottom row
            if (32'(diag_nx) < 32'(row_side))
            begin
                next_row = POS_W'(diag_nx);
                next_col = '0;
            end
            else
            begin
                next_row = POS_W'(row_max);
                next_col = POS_W'(diag_nx - D_W'(row_max));
            end
        end
        else
        begin
            // odd diagonal starts on the top row, else on the right edge
            if (32'(diag_nx) < 32'(col_side))
            begin
                next_row = '0;
                next_col = POS_W'(diag_nx);
            end
            else
            begin
                next_row = POS_W'(diag_nx - D_W'(col_max));
                next_col = POS_W'(col_max);
            end
        end
    end

    assign next_diag        = D_W'(next_row) + D_W'(next_col);
    assign flags.diag_first = to_origin || !(up_right || down_left);
    assign flags.scan_last  = (SIDE_W'(next_row) == row_max) &&
                              (SIDE_W'(next_col) == col_max);

endmodule

@@ rtl/zsig_checker.sv @@
module zsig_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       restart,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [5:0] row_index,
    input  logic [5:0] col_index,
    input  logic [6:0] diag_number,
    input  logic       diag_first
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(col_index))
        else $error("stalled result changed");

    // an accepted restart shows the origin on the next cycle
    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && restart |=>
            out_valid && row_index == 6'd0 && col_index == 6'd0 && diag_first)
        else $error("restart did not yield the origin");

    // diagonal number tracks row plus column
    a_diag_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> diag_number == (7'(row_index) + 7'(col_index)))
        else $error("diag_number mismatch");

    // the origin always opens a diagonal
    a_origin_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_index == 6'd0 && col_index == 6'd0 |-> diag_first)
        else $error("origin without diag_first");

endmodule

bind zigzag_scan_index_generator zsig_checker u_zsig_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_index   (row_index),
    .col_index   (col_index),
    .diag_number (diag_number),
    .diag_first  (diag_first)
);

@@ tb/zigzag_scan_index_generator_tb.sv @@
module zigzag_scan_index_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycle budget: roughly 1000 items at worst-case gaps and stalls, plus the
    // long receiver hold and the idle pauses around every register write.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 760;
    localparam int LONG_HOLD    = 400;

    // One result item as the scan produces it
    typedef struct {
        logic [zsig_pkg::IDX_W-1:0]  row_idx;
        logic [zsig_pkg::IDX_W-1:0]  col_idx;
        logic [zsig_pkg::DIAG_W-1:0] diag;
        logic                        diag_first;
        logic                        scan_last;
    } scan_elem_t;

    // Receiver stall patterns, each held for a random segment of cycles
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    // ------------------------------------------------------------------
    // Clock, reset, block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_write = 1'b0;
    logic [zsig_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [zsig_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic in_valid  = 1'b0;
    logic restart   = 1'b0;
    logic out_stall = 1'b0;

    logic                          in_stall;
    logic                          out_valid;
    logic [zsig_pkg::IDX_W-1:0]    row_index;
    logic [zsig_pkg::IDX_W-1:0]    col_index;
    logic [zsig_pkg::DIAG_W-1:0]   diag_number;
    logic                          diag_first;
    logic                          scan_last;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    zigzag_scan_index_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .col_index   (col_index),
        .diag_number (diag_number),
        .diag_first  (diag_first),
        .scan_last   (scan_last)
    );

    // ------------------------------------------------------------------
    // Scan predictor state: register contents as written, plus the last
    // position handed out. Registers keep the raw 7-bit value; clamping to
    // 1..64 happens on use.
    // ------------------------------------------------------------------
    int row_reg = zsig_pkg::SIDE_RESET;
    int col_reg = zsig_pkg::SIDE_RESET;
    int pos_row = 0;
    int pos_col = 0;
    bit scan_on = 1'b0;

    logic       req_q[$];     // restart bits still to be offered
    scan_elem_t scan_q[$];    // predicted elements not yet seen at the output

    int failures       = 0;
    int items_accepted = 0;
    int cycle_count    = 0;

    function automatic int side_of(input int v);
        if (v < 1)
            return 1;
        if (v > zsig_pkg::MAX_SIDE_DEF)
            return zsig_pkg::MAX_SIDE_DEF;
        return v;
    endfunction

    // Next element of the zigzag walk for one accepted item
    function automatic scan_elem_t advance_scan(input logic req_restart);
        int nr;
        int nc;
        int d;
        int nd;
        scan_elem_t e;
        nr = side_of(row_reg);
        nc = side_of(col_reg);
        e.diag_first = 1'b1;
        // back to the origin: restart, no scan yet, after the corner, or the
        // stored position fell outside a shrunken matrix
        if (req_restart || !scan_on || pos_row >= nr || pos_col >= nc ||
            (pos_row == nr - 1 && pos_col == nc - 1))
        begin
            pos_row = 0;
            pos_col = 0;
            scan_on = 1'b1;
        end
        else
        begin
            d = pos_row + pos_col;
            if (d % 2 == 0 && pos_row > 0 && pos_col + 1 < nc)
            begin
                // even diagonal runs up-right
                pos_row--;
                pos_col++;
                e.diag_first = 1'b0;
            end
            else if (d % 2 == 1 && pos_row + 1 < nr && pos_col > 0)
            begin
                // odd diagonal runs down-left
                pos_row++;
                pos_col--;
                e.diag_first = 1'b0;
            end
            else
            begin
                nd = d + 1;
                if (nd % 2 == 0)
                begin
                    if (nd < nr)
                    begin
                        pos_row = nd;
                        pos_col = 0;
                    end
                    else
                    begin
                        pos_row = nr - 1;
                        pos_col = nd - (nr - 1);
                    end
                end
                else
                begin
                    if (nd < nc)
                    begin
                        pos_row = 0;
                        pos_col = nd;
                    end
                    else
                    begin
                        pos_row = nd - (nc - 1);
                        pos_col = nc - 1;
                    end
                end
            end
        end
        e.row_idx   = zsig_pkg::IDX_W'(pos_row);
        e.col_idx   = zsig_pkg::IDX_W'(pos_col);
        e.diag      = zsig_pkg::DIAG_W'(pos_row + pos_col);
        e.scan_last = (pos_row == nr - 1 && pos_col == nc - 1);
        return e;
    endfunction

    // Mostly small sides, sometimes large, the extremes, and out-of-range
    // values that the block must clamp
    function automatic int pick_side();
        int sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(1, 8);
        if (sel < 80)
            return $urandom_range(9, 64);
        if (sel < 92)
            return $urandom_range(0, 1) ? 1 : 64;
        if (sel < 96)
            return 0;
        return $urandom_range(65, 127);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // Valid drops only after acceptance, never because of in_stall.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                scan_q.push_back(advance_scan(restart));
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    restart  <= req_q.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        // half the bursts run straight into the next one
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern. Once enough items have gone through, it holds
    // off for a long stretch so the result register fills and the block
    // backs up onto its input.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int  seg_left  = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        logic stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_next = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!hold_done && items_accepted >= 300)
            begin
                hold_done  = 1'b1;
                hold_left  = LONG_HOLD - 1;
                stall_next = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left   = $urandom_range(16, 160);
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (stall_mode)
                    STALL_NONE:   stall_next = 1'b0;
                    STALL_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: stall_next = !out_stall;
                    default:      stall_next = 1'b0;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        scan_elem_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (scan_q.size() == 0)
            begin
                $error("result item with nothing pending: row %0d col %0d",
                       row_index, col_index);
                failures++;
            end
            else
            begin
                want = scan_q.pop_front();
                if (row_index !== want.row_idx)
                begin
                    $error("row_index: expected %0d, got %0d", want.row_idx, row_index);
                    failures++;
                end
                if (col_index !== want.col_idx)
                begin
                    $error("col_index: expected %0d, got %0d", want.col_idx, col_index);
                    failures++;
                end
                if (diag_number !== want.diag)
                begin
                    $error("diag_number: expected %0d, got %0d", want.diag, diag_number);
                    failures++;
                end
                if (diag_first !== want.diag_first)
                begin
                    $error("diag_first: expected %0d, got %0d", want.diag_first, diag_first);
                    failures++;
                end
                if (scan_last !== want.scan_last)
                begin
                    $error("scan_last: expected %0d, got %0d", want.scan_last, scan_last);
                    failures++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // Block until every queued item is accepted and every result seen, then
    // allow the result register to settle.
    task automatic wait_idle();
        @(negedge clk);
        while (req_q.size() != 0 || in_valid || scan_q.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Called right after a rising edge. Drops cfg_write again before returning
    // so back-to-back writes never stack two updates on cfg_write.
    task automatic write_reg(input logic [zsig_pkg::REG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= zsig_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == zsig_pkg::REG_ROW_COUNT)
            row_reg = value & 8'h7f;
        else
            col_reg = value & 8'h7f;
    endtask

    initial
    begin
        int k;
        int n;
        int area;
        int random_items;

        random_items = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes 8x8: first advance with no scan running, a few steps,
        // a restart mid-diagonal, then carry on
        req_q = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        wait_idle();

        // 1x1: every element is the last one, so each advance wraps
        write_reg(zsig_pkg::REG_ROW_COUNT, 1);
        write_reg(zsig_pkg::REG_COL_COUNT, 1);
        req_q = '{1'b0, 1'b0, 1'b1};
        wait_idle();

        // Out-of-range sides: zero acts as one, 127 acts as 64
        write_reg(zsig_pkg::REG_ROW_COUNT, 0);
        write_reg(zsig_pkg::REG_COL_COUNT, 127);
        req_q = '{1'b1, 1'b0, 1'b0};
        wait_idle();

        // Walk 8x8 to (1,1), then resize mid-scan: first to 2 rows where the
        // position still fits, then to 1 row, where its place on row 0 fits too
        write_reg(zsig_pkg::REG_ROW_COUNT, 8);
        write_reg(zsig_pkg::REG_COL_COUNT, 8);
        req_q = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        wait_idle();
        write_reg(zsig_pkg::REG_ROW_COUNT, 2);
        req_q = '{1'b0, 1'b0};
        wait_idle();
        write_reg(zsig_pkg::REG_ROW_COUNT, 1);
        req_q = '{1'b0, 1'b0};
        wait_idle();

        // Corner climb: run down a 64x1 column to (63,0), then widen the
        // matrix by one column at a time. Sitting at the far corner, each
        // widening moves on to (63,c+1) in one or two steps, so the walk
        // reaches (63,63) on diagonal 126 without a full 4096-element scan.
        write_reg(zsig_pkg::REG_ROW_COUNT, 64);
        write_reg(zsig_pkg::REG_COL_COUNT, 1);
        req_q.push_back(1'b1);
        repeat (63) req_q.push_back(1'b0);
        for (k = 0; k < 63; k++)
        begin
            wait_idle();
            write_reg(zsig_pkg::REG_COL_COUNT, k + 2);
            req_q.push_back(1'b0);
            if (k % 2 == 1)
                req_q.push_back(1'b0);
        end
        // one more advance wraps off the 64x64 corner
        req_q.push_back(1'b0);
        wait_idle();

        // Random phases: new sizes (often mid-scan) then a run of advances
        // with occasional restarts. Small matrices often get one to three whole
        // scans, so wrap-around happens often.
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_reg(zsig_pkg::REG_ROW_COUNT, pick_side());
            if ($urandom_range(0, 2) == 0)
                write_reg(zsig_pkg::REG_COL_COUNT, pick_side());
            area = side_of(row_reg) * side_of(col_reg);
            if (area <= 64 && $urandom_range(0, 1) == 1)
                n = area * $urandom_range(1, 3) + $urandom_range(0, 3);
            else
                n = $urandom_range(8, 60);
            for (k = 0; k < n; k++)
                req_q.push_back($urandom_range(0, 19) == 0);
            random_items += n;
            wait_idle();
        end

        // catch any stray result after the last expected one
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
